// File: sv/rbel_pkg.sv
package rbel_pkg;

    // Fixed field widths
    localparam int unsigned DATA_W    = 64;
    localparam int unsigned PAT_W     = 8;
    localparam int unsigned ROW_W     = 14;
    localparam int unsigned ROWS_W    = 15;
    localparam int unsigned COL_OUT_W = 5;
    localparam int unsigned BIT_W     = 8;
    localparam int unsigned BIT_IDX_W = 6;
    localparam int unsigned WIDX_OUT_W = BIT_W - BIT_IDX_W;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned CFG_W     = 15;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PATTERN_BYTE     = 2'd0;
    localparam t_cfg_idx CFG_SELECTED_CHANNEL = 2'd1;
    localparam t_cfg_idx CFG_FIRST_ROW        = 2'd2;
    localparam t_cfg_idx CFG_ROWS_TO_CHECK    = 2'd3;

    localparam logic [ROWS_W-1:0] ROWS_TO_CHECK_RST = 15'd8;

    // Location of the word at the head of the stream
    typedef struct packed {
        logic [ROW_W-1:0]      row;
        logic [COL_OUT_W-1:0]  column;
        logic [WIDX_OUT_W-1:0] widx;
        logic                  check;   // word belongs to the selected channel
        logic                  active;  // rows remain to be checked
    } t_word_info;

    // Status of the flip scanner
    typedef struct packed {
        logic busy;   // cannot take a new word this cycle
        logic emit;   // a flip moves into the output register
        logic last;   // the emitted flip is the last of its word
    } t_scan_stat;

endpackage

// File: sv/rbel_position.sv
module rbel_position #(
    parameter int unsigned COLUMNS         = 32,
    parameter int unsigned WORDS_PER_BURST = 4,
    parameter int unsigned CHANNELS        = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_selected_channel,
    input  logic [rbel_pkg::ROW_W-1:0]       i_first_row,
    input  logic [rbel_pkg::ROWS_W-1:0]      i_rows_to_check,
    output rbel_pkg::t_word_info             o_info
);

    localparam int unsigned WIDX_W = (WORDS_PER_BURST > 1) ? $clog2(WORDS_PER_BURST) : 1;
    localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(WORDS_PER_BURST - 1);
    localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(CHANNELS - 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);

    logic [WIDX_W-1:0]               r_widx,  n_widx;
    logic [CH_W-1:0]                 r_ch,    n_ch;
    logic [COL_W-1:0]                r_col,   n_col;
    logic [rbel_pkg::ROWS_W-1:0]     r_row_offset, n_row_offset;

    logic        w_active;
    logic        w_widx_wrap;
    logic        w_ch_wrap;
    logic        w_col_wrap;
    logic [15:0] w_col_ext;
    logic [15:0] w_widx_ext;

    assign w_active    = r_row_offset < i_rows_to_check;
    assign w_widx_wrap = r_widx == WIDX_LAST;
    assign w_ch_wrap   = r_ch == CH_LAST;
    assign w_col_wrap  = r_col == COL_LAST;
    assign w_col_ext   = 16'(r_col);
    assign w_widx_ext  = 16'(r_widx);

    // Describe the word at the head of the stream
    always_comb begin
        o_info.row    = i_first_row + r_row_offset[rbel_pkg::ROW_W-1:0];
        o_info.column = w_col_ext[rbel_pkg::COL_OUT_W-1:0];
        o_info.widx   = w_widx_ext[rbel_pkg::WIDX_OUT_W-1:0];
        o_info.check  = 4'(r_ch) == 4'(i_selected_channel);
        o_info.active = w_active;
    end

    // Advance word, channel, column and row counters as nested wraps
    always_comb begin
        n_widx       = r_widx;
        n_ch         = r_ch;
        n_col        = r_col;
        n_row_offset = r_row_offset;
        if (i_accept && w_active) begin
            n_widx = w_widx_wrap ? '0 : r_widx + 1'b1;
            if (w_widx_wrap) begin
                n_ch = w_ch_wrap ? '0 : r_ch + 1'b1;
                if (w_ch_wrap) begin
                    n_col = w_col_wrap ? '0 : r_col + 1'b1;
                    if (w_col_wrap) begin
                        n_row_offset = r_row_offset + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx       <= '0;
            r_ch         <= '0;
            r_col        <= '0;
            r_row_offset <= '0;
        end else begin
            r_widx       <= n_widx;
            r_ch         <= n_ch;
            r_col        <= n_col;
            r_row_offset <= n_row_offset;
        end
    end

endmodule

// File: sv/rbel_flip_scan.sv
module rbel_flip_scan (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic [rbel_pkg::DATA_W-1:0]       i_data_word,
    input  logic [rbel_pkg::PAT_W-1:0]        i_pattern_byte,
    input  rbel_pkg::t_word_info              i_info,
    input  logic                              i_stall,
    output rbel_pkg::t_scan_stat              o_stat,
    output logic                              o_valid,
    output logic [rbel_pkg::ROW_W-1:0]        o_row,
    output logic [rbel_pkg::COL_OUT_W-1:0]    o_column,
    output logic [rbel_pkg::BIT_W-1:0]        o_bit_in_burst,
    output logic [rbel_pkg::CNT_W-1:0]        o_flip_total,
    output logic                              o_last
);

    // Word being reported
    logic [rbel_pkg::DATA_W-1:0]      r_mask, n_mask;
    logic [rbel_pkg::ROW_W-1:0]       r_row;
    logic [rbel_pkg::COL_OUT_W-1:0]   r_col;
    logic [rbel_pkg::WIDX_OUT_W-1:0]  r_widx;
    logic [rbel_pkg::CNT_W-1:0]       r_flips, n_flips;

    // Output register
    logic                             r_out_valid;
    logic [rbel_pkg::ROW_W-1:0]       r_out_row;
    logic [rbel_pkg::COL_OUT_W-1:0]   r_out_col;
    logic [rbel_pkg::BIT_W-1:0]       r_out_bit;
    logic [rbel_pkg::CNT_W-1:0]       r_out_total;
    logic                             r_out_last;

    logic [rbel_pkg::DATA_W-1:0]      w_expected;
    logic [rbel_pkg::DATA_W-1:0]      w_lowest;
    logic [rbel_pkg::DATA_W-1:0]      w_rest;
    logic [rbel_pkg::BIT_IDX_W-1:0]   w_bit_idx;
    logic                             w_pending;
    logic                             w_emit;
    logic                             w_last;

    assign w_expected = {(rbel_pkg::DATA_W / rbel_pkg::PAT_W){i_pattern_byte}};
    assign w_pending  = r_mask != '0;

    // Isolate the lowest pending flip and clear it from the mask
    assign w_lowest = r_mask & (~r_mask + 1'b1);
    assign w_rest   = r_mask & (r_mask - 1'b1);
    assign w_last   = w_rest == '0;

    // Encode the position of the isolated bit
    always_comb begin
        w_bit_idx = '0;
        for (int i = 0; i < rbel_pkg::DATA_W; i++) begin
            w_bit_idx = w_bit_idx | (w_lowest[i] ? rbel_pkg::BIT_IDX_W'(i) : '0);
        end
    end

    // Emit one flip per cycle while the output register is free
    assign w_emit = w_pending && (!r_out_valid || !i_stall);

    always_comb begin
        o_stat.busy = w_pending && !(w_emit && w_last);
        o_stat.emit = w_emit;
        o_stat.last = w_last;
    end

    // Load a new word or strip the emitted flip
    always_comb begin
        n_mask  = r_mask;
        n_flips = r_flips;
        if (w_emit) begin
            n_mask = w_rest;
            if (r_flips != '1) begin
                n_flips = r_flips + 1'b1;
            end
        end
        if (i_load) begin
            n_mask = i_data_word ^ w_expected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_flips     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask  <= n_mask;
            r_flips <= n_flips;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the location of the loaded word
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_row  <= i_info.row;
            r_col  <= i_info.column;
            r_widx <= i_info.widx;
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_row   <= r_row;
            r_out_col   <= r_col;
            r_out_bit   <= {r_widx, w_bit_idx};
            r_out_total <= n_flips;
            r_out_last  <= w_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_row          = r_out_row;
    assign o_column       = r_out_col;
    assign o_bit_in_burst = r_out_bit;
    assign o_flip_total   = r_out_total;
    assign o_last         = r_out_last;

endmodule

// File: sv/retention_bit_error_locator.sv
// An accepted word's flips go from the pending mask register to the output register.
// Throughput: one word per cycle when it has no flips, outside the selected channel,
// or past the row count; a word with flips stalls input until its last flip, as
// the lowest-set-bit unit gives the output register one flip per cycle unless stalled.
// Reset (synchronous, active low): counters, flip total and pending mask clear,
// registers return to pattern 0, channel 0, first row 0, eight rows to check.
module retention_bit_error_locator #(
    parameter int unsigned COLUMNS         = 32,
    parameter int unsigned WORDS_PER_BURST = 4,
    parameter int unsigned CHANNELS        = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration
    input  logic                              i_cfg_we,
    input  rbel_pkg::t_cfg_idx                i_cfg_index,
    input  logic [rbel_pkg::CFG_W-1:0]        i_cfg_data,
    // Readback words
    input  logic                              i_valid,
    input  logic [rbel_pkg::DATA_W-1:0]       i_data_word,
    output logic                              o_stall,
    // Flip results
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [rbel_pkg::ROW_W-1:0]        o_row,
    output logic [rbel_pkg::COL_OUT_W-1:0]    o_column,
    output logic [rbel_pkg::BIT_W-1:0]        o_bit_in_burst,
    output logic [rbel_pkg::CNT_W-1:0]        o_flip_total,
    output logic                              o_last
);

    logic [rbel_pkg::PAT_W-1:0]   r_pattern_byte;
    logic                         r_selected_channel;
    logic [rbel_pkg::ROW_W-1:0]   r_first_row;
    logic [rbel_pkg::ROWS_W-1:0]  r_rows_to_check;

    rbel_pkg::t_word_info  w_info;
    rbel_pkg::t_scan_stat  w_stat;
    logic                  w_accept;
    logic                  w_load;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_byte     <= '0;
            r_selected_channel <= 1'b0;
            r_first_row        <= '0;
            r_rows_to_check    <= rbel_pkg::ROWS_TO_CHECK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rbel_pkg::CFG_PATTERN_BYTE: begin
                    r_pattern_byte <= i_cfg_data[rbel_pkg::PAT_W-1:0];
                end
                rbel_pkg::CFG_SELECTED_CHANNEL: begin
                    r_selected_channel <= i_cfg_data[0];
                end
                rbel_pkg::CFG_FIRST_ROW: begin
                    r_first_row <= i_cfg_data[rbel_pkg::ROW_W-1:0];
                end
                rbel_pkg::CFG_ROWS_TO_CHECK: begin
                    r_rows_to_check <= i_cfg_data[rbel_pkg::ROWS_W-1:0];
                end
            endcase
        end
    end

    // Take a request whenever the scanner frees up
    assign o_stall  = w_stat.busy;
    assign w_accept = i_valid && !o_stall;
    assign w_load   = w_accept && w_info.active && w_info.check;

    rbel_position #(
        .COLUMNS         (COLUMNS),
        .WORDS_PER_BURST (WORDS_PER_BURST),
        .CHANNELS        (CHANNELS)
    ) u_position (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (w_accept),
        .i_selected_channel (r_selected_channel),
        .i_first_row        (r_first_row),
        .i_rows_to_check    (r_rows_to_check),
        .o_info             (w_info)
    );

    rbel_flip_scan u_flip_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_load),
        .i_data_word    (i_data_word),
        .i_pattern_byte (r_pattern_byte),
        .i_info         (w_info),
        .i_stall        (i_stall),
        .o_stat         (w_stat),
        .o_valid        (o_valid),
        .o_row          (o_row),
        .o_column       (o_column),
        .o_bit_in_burst (o_bit_in_burst),
        .o_flip_total   (o_flip_total),
        .o_last         (o_last)
    );

    // An emitted flip shows up as a result on the next cycle
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.emit |=> o_valid)
        else $error("emitted flip did not reach the output register");

    // A word past the row count leaves nothing to report
    a_exhausted_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_info.active) |=> !w_stat.busy)
        else $error("word past the row count started a scan");

    // Every reported flip has been counted
    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_flip_total != '0))
        else $error("flip result carries a zero running total");

    // The last flip of a word frees the input in the same cycle
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.emit && w_stat.last) |-> !o_stall)
        else $error("input stayed stalled after the last flip of a word");

endmodule

// File: tb/sv/retention_bit_error_locator_tb.sv
`timescale 1ns / 100ps

module retention_bit_error_locator_tb;

    localparam int STALL_LIMIT = 3000;
    localparam int PROBES      = 16;

    // One located flip, in output field order
    typedef struct packed {
        logic [rbel_pkg::ROW_W-1:0]     row;
        logic [rbel_pkg::COL_OUT_W-1:0] column;
        logic [rbel_pkg::BIT_W-1:0]     bit_in_burst;
        logic [rbel_pkg::CNT_W-1:0]     flip_total;
        logic                           last;
    } t_bit_flip;

    // Directed readback word with an optional hand-written expectation
    typedef struct {
        logic [rbel_pkg::DATA_W-1:0] word;
        bit                          typed;     // expectation given below, not predicted
        bit                          one_flip;  // typed: a single flip, otherwise none
        t_bit_flip                   flip;
    } t_probe;

    // Register setting and traffic shape of one random stretch
    typedef struct {
        logic [rbel_pkg::PAT_W-1:0]  pattern;
        logic                        channel;
        logic [rbel_pkg::ROW_W-1:0]  first_row;
        logic [rbel_pkg::ROWS_W-1:0] rows;
        int                          items;
        int                          send_pct;
        int                          recv_pct;
    } t_phase;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    rbel_pkg::t_cfg_idx             i_cfg_index = rbel_pkg::CFG_PATTERN_BYTE;
    logic [rbel_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                           i_valid = 1'b0;
    logic [rbel_pkg::DATA_W-1:0]    i_data_word = '0;
    logic                           o_stall;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic [rbel_pkg::ROW_W-1:0]     o_row;
    logic [rbel_pkg::COL_OUT_W-1:0] o_column;
    logic [rbel_pkg::BIT_W-1:0]     o_bit_in_burst;
    logic [rbel_pkg::CNT_W-1:0]     o_flip_total;
    logic                           o_last;

    // Shadow registers and scan state
    logic [rbel_pkg::PAT_W-1:0]     exp_pattern = '0;
    logic                           exp_channel = 1'b0;
    logic [rbel_pkg::ROW_W-1:0]     exp_first_row = '0;
    logic [rbel_pkg::ROWS_W-1:0]    exp_rows = rbel_pkg::ROWS_TO_CHECK_RST;
    logic [7:0]                     word_pos = '0;
    logic [rbel_pkg::ROWS_W-1:0]    rows_done = '0;
    logic [rbel_pkg::CNT_W-1:0]     flips_seen = '0;

    t_bit_flip            flips_due[$];
    t_probe               probes[PROBES];
    t_phase               phases[4];
    int                   mismatches = 0;
    int                   send_pct = 33;
    int                   recv_pct = 63;
    int                   idle_cycles = 0;

    retention_bit_error_locator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_data_word    (i_data_word),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_row          (o_row),
        .o_column       (o_column),
        .o_bit_in_burst (o_bit_in_burst),
        .o_flip_total   (o_flip_total),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Compare one readback word against the pattern and advance the scan position
    function automatic void locate_flips(input logic [rbel_pkg::DATA_W-1:0] word,
                                         ref t_bit_flip found[$]);
        logic [rbel_pkg::DATA_W-1:0] diff;
        t_bit_flip                   f;
        if (rows_done >= exp_rows)
            return;
        if (word_pos[2] == exp_channel) begin
            diff = word ^ {8{exp_pattern}};
            for (int b = 0; b < rbel_pkg::DATA_W; b++) begin
                if (diff[b]) begin
                    diff[b] = 1'b0;
                    if (flips_seen != '1)
                        flips_seen = flips_seen + 1'b1;
                    f.row          = exp_first_row + rows_done[rbel_pkg::ROW_W-1:0];
                    f.column       = word_pos[7:3];
                    f.bit_in_burst = {word_pos[1:0], 6'(b)};
                    f.flip_total   = flips_seen;
                    f.last         = (diff == '0);
                    found.push_back(f);
                end
            end
        end
        word_pos = word_pos + 1'b1;
        if (word_pos == '0)
            rows_done = rows_done + 1'b1;
    endfunction

    // Mostly clean or lightly disturbed pattern words, some heavy damage
    function automatic logic [rbel_pkg::DATA_W-1:0] make_word();
        logic [rbel_pkg::DATA_W-1:0] w;
        int unsigned                 pick;
        int                          k;
        w = {8{exp_pattern}};
        pick = $urandom_range(99);
        if (pick >= 95) begin
            w = ~w;
        end else if (pick >= 85) begin
            w = {$urandom, $urandom};
        end else if (pick >= 75) begin
            w = w ^ ({$urandom, $urandom} & {$urandom, $urandom});
        end else if (pick >= 40) begin
            repeat ($urandom_range(1, 3)) begin
                k = $urandom_range(rbel_pkg::DATA_W - 1);
                w[k] = ~w[k];
            end
        end
        return w;
    endfunction

    function automatic void note_mismatch(string what, t_bit_flip want, t_bit_flip got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected row %0d col %0d bit %0d total %0d last %0b",
                     what, want.row, want.column, want.bit_in_burst, want.flip_total,
                     want.last);
            $display("    got row %0d col %0d bit %0d total %0d last %0b",
                     got.row, got.column, got.bit_in_burst, got.flip_total, got.last);
        end
    endfunction

    // Present one word and hold it until the block takes it
    task automatic push_word(input logic [rbel_pkg::DATA_W-1:0] word);
        while (send_pct != 0 && $urandom_range(99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_word <= word;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic write_reg(input rbel_pkg::t_cfg_idx idx,
                             input logic [rbel_pkg::CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            rbel_pkg::CFG_PATTERN_BYTE:     exp_pattern   = value[rbel_pkg::PAT_W-1:0];
            rbel_pkg::CFG_SELECTED_CHANNEL: exp_channel   = value[0];
            rbel_pkg::CFG_FIRST_ROW:        exp_first_row = value[rbel_pkg::ROW_W-1:0];
            rbel_pkg::CFG_ROWS_TO_CHECK:    exp_rows      = value[rbel_pkg::ROWS_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every expected flip has come out and the scanner has settled
    task automatic drain();
        while (flips_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Check results and drive the result-side stall
    always @(posedge i_clk) begin
        t_bit_flip got;
        t_bit_flip want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_row, o_column, o_bit_in_burst, o_flip_total, o_last};
            if (flips_due.size() == 0) begin
                note_mismatch("unexpected flip", '0, got);
            end else begin
                want = flips_due.pop_front();
                if (got !== want)
                    note_mismatch("flip mismatch", want, got);
            end
        end
        i_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        t_bit_flip                   found[$];
        logic [rbel_pkg::DATA_W-1:0] w;

        // Reset setting: pattern 0, channel 0, first row 0, eight rows
        probes[0]  = '{64'h0000_0000_0000_0001, 1'b1, 1'b1, {14'd0, 5'd0, 8'd0, 32'd1, 1'b1}};
        probes[1]  = '{64'h8000_0000_0000_0000, 1'b1, 1'b1, {14'd0, 5'd0, 8'd127, 32'd2, 1'b1}};
        probes[2]  = '{64'h0000_0000_0000_0000, 1'b1, 1'b0, '0};
        probes[3]  = '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0};
        // Channel 1 words are skipped whatever the data; probes 8 to 11 are channel 0 words
        probes[4]  = '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, '0};
        probes[5]  = '{64'hDEAD_BEEF_0123_4567, 1'b1, 1'b0, '0};
        probes[6]  = '{64'h0000_0000_0000_0000, 1'b1, 1'b0, '0};
        probes[7]  = '{64'h5555_5555_5555_5555, 1'b1, 1'b0, '0};
        probes[8]  = '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0};
        probes[9]  = '{64'h5555_5555_5555_5555, 1'b0, 1'b0, '0};
        probes[10] = '{64'h8000_0000_0000_0001, 1'b0, 1'b0, '0};
        probes[11] = '{64'h0000_0001_0000_0000, 1'b0, 1'b0, '0};
        probes[12] = '{64'hFF00_0000_0000_00FF, 1'b1, 1'b0, '0};
        probes[13] = '{64'h0000_0000_0000_0000, 1'b1, 1'b0, '0};
        probes[14] = '{64'h00FF_00FF_00FF_00FF, 1'b1, 1'b0, '0};
        probes[15] = '{64'h0000_0000_0000_0000, 1'b1, 1'b0, '0};

        // Walk the register extremes; the row counter keeps running across phases
        phases[0] = '{8'hFF, 1'b1, 14'd16383, 15'd16384, 160, 33, 63};
        phases[1] = '{8'hA5, 1'b0, 14'd16383, 15'd2, 120, 63, 33};
        phases[2] = '{rbel_pkg::PAT_W'($urandom), 1'b1, 14'd0, 15'd0, 30, 0, 0};
        phases[3] = '{rbel_pkg::PAT_W'($urandom), 1'b0,
                      rbel_pkg::ROW_W'($urandom_range(16383)), 15'd16384, 230, 0, 0};

        // Hold reset, then release it
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at the reset setting
        for (int n = 0; n < PROBES; n++) begin
            push_word(probes[n].word);
            found.delete();
            locate_flips(probes[n].word, found);
            if (probes[n].typed) begin
                if (probes[n].one_flip)
                    flips_due.push_back(probes[n].flip);
            end else begin
                foreach (found[j])
                    flips_due.push_back(found[j]);
            end
        end
        i_valid <= 1'b0;
        drain();

        // Random words per register setting
        foreach (phases[p]) begin
            write_reg(rbel_pkg::CFG_PATTERN_BYTE, rbel_pkg::CFG_W'(phases[p].pattern));
            write_reg(rbel_pkg::CFG_SELECTED_CHANNEL, rbel_pkg::CFG_W'(phases[p].channel));
            write_reg(rbel_pkg::CFG_FIRST_ROW, rbel_pkg::CFG_W'(phases[p].first_row));
            write_reg(rbel_pkg::CFG_ROWS_TO_CHECK, rbel_pkg::CFG_W'(phases[p].rows));
            send_pct = phases[p].send_pct;
            recv_pct = phases[p].recv_pct;
            repeat (phases[p].items) begin
                w = make_word();
                push_word(w);
                locate_flips(w, flips_due);
            end
            i_valid <= 1'b0;
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && flips_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
